// ----- design/ksa_pkg.sv -----
// ----------------------------------------------------------------------------
// ksa_pkg
// Shared codes, controller/datapath command and status words, sine function.
// ----------------------------------------------------------------------------
package ksa_pkg;

   localparam logic [1:0] MODE_STATIC = 2'd0;
   localparam logic [1:0] MODE_OSC    = 2'd1;
   localparam logic [1:0] MODE_KEYS   = 2'd2;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_MODE  = 3'd0;
   localparam logic [2:0] REG_AMP   = 3'd1;
   localparam logic [2:0] REG_FREQ  = 3'd2;
   localparam logic [2:0] REG_PHASE = 3'd3;
   localparam logic [2:0] REG_LOOP  = 3'd4;
   localparam logic [2:0] REG_COUNT = 3'd5;

   localparam int DIV_STEPS = 64;
   localparam int CNT_W     = 6;

   localparam logic [4:0] OP_IDLE     = 5'd0;
   localparam logic [4:0] OP_LOAD     = 5'd1;
   localparam logic [4:0] OP_CAPTURE  = 5'd2;
   localparam logic [4:0] OP_OSC_MUL  = 5'd3;
   localparam logic [4:0] OP_OSC_SIN  = 5'd4;
   localparam logic [4:0] OP_OSC_AMP  = 5'd5;
   localparam logic [4:0] OP_OSC_FIN  = 5'd6;
   localparam logic [4:0] OP_KEY0     = 5'd7;
   localparam logic [4:0] OP_RES_RD   = 5'd8;
   localparam logic [4:0] OP_LOAD_MOD = 5'd9;
   localparam logic [4:0] OP_T_PLAIN  = 5'd10;
   localparam logic [4:0] OP_DIV_STEP = 5'd11;
   localparam logic [4:0] OP_WRAP     = 5'd12;
   localparam logic [4:0] OP_ADVANCE  = 5'd13;
   localparam logic [4:0] OP_SEG      = 5'd14;
   localparam logic [4:0] OP_MUL_LO   = 5'd15;
   localparam logic [4:0] OP_MUL_HI   = 5'd16;
   localparam logic [4:0] OP_MUL_SUM  = 5'd17;
   localparam logic [4:0] OP_LOAD_DIV = 5'd18;
   localparam logic [4:0] OP_RES_VA   = 5'd19;
   localparam logic [4:0] OP_RES_SAT  = 5'd20;
   localparam logic [4:0] OP_RES_QUOT = 5'd21;
   localparam logic [4:0] OP_EMIT     = 5'd22;

   typedef struct packed {
      logic [4:0] op;
      logic       rd_en;
   } cmd_type;

   typedef struct packed {
      logic wrap;
      logic hit;
      logic dt_pos;
      logic ovf;
   } status_type;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   function automatic logic [16:0] quarter_sine(input int unsigned r,
                                                input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] q16;
      x   = (64'(r) * HALF_PI_Q30) >> qbits;
      x2  = (x * x) >> 30;
      t   = ONE_Q30 - ((x2 * ONE_Q30) >> 30) / 64'd110;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s   = (x * t) >> 30;
      q16 = (s + 64'd8192) >> 14;
      if (q16 > 64'd65536) begin
         q16 = 64'd65536;
      end
      return q16[16:0];
   endfunction

endpackage

// ----- design/ksa_dpath.sv -----
// ----------------------------------------------------------------------------
// ksa_dpath
// Key table, sine table, multipliers, shared bit-serial divider, result regs.
// ----------------------------------------------------------------------------
module ksa_dpath #(
   parameter int MAX_KEYS        = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                          clock,
   input  ksa_pkg::cmd_type              cmd,
   input  logic [$clog2(MAX_KEYS)-1:0]   rd_addr,
   output ksa_pkg::status_type           status,
   input  logic [3:0]                    req_key_index,
   input  logic signed [31:0]            req_key_time,
   input  logic signed [31:0]            req_key_value,
   input  logic signed [31:0]            req_sample_time,
   input  logic signed [31:0]            req_base_value,
   input  logic signed [31:0]            osc_amplitude,
   input  logic signed [31:0]            osc_frequency,
   input  logic [15:0]                   osc_phase_turns,
   input  logic                          loop_enable,
   output logic signed [31:0]            rsp_anim_value
);
   import ksa_pkg::*;

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QSIZE = 1 << QBITS;
   localparam int LIW   = QBITS + 1;

   logic signed [31:0] times_mem  [MAX_KEYS];
   logic signed [31:0] values_mem [MAX_KEYS];
   logic signed [31:0] rd_time_ff;
   logic signed [31:0] rd_val_ff;

   logic [16:0] sine_lut [QSIZE+1];

   logic signed [31:0] time_ff, time_in, base_ff, base_in, res_ff, res_in;
   logic signed [31:0] ta_ff, ta_in, va_ff, va_in, out_ff, out_in;
   logic signed [32:0] t_ff, t_in;
   logic [31:0]        ang_ff, ang_in;
   logic signed [17:0] sin_ff, sin_in;
   logic signed [49:0] oprod_ff, oprod_in;
   logic [33:0]        ua_ff, ua_in;
   logic [32:0]        ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [31:0]        den_ff, den_in;
   logic [49:0]        pplo_ff, pplo_in, pphi_ff, pphi_in;
   logic [65:0]        prod_ff, prod_in;
   logic [63:0]        dq_ff, dq_in;
   logic [31:0]        rem_ff, rem_in;

   logic [AW-1:0]          widx;
   logic                   key_ok;
   logic signed [32:0]     span33;
   logic signed [32:0]     mdiff;
   logic [32:0]            mmag;
   logic signed [33:0]     adiff;
   logic [33:0]            amag;
   logic signed [32:0]     dv33;
   logic [32:0]            vmag;
   logic [32:0]            rs;
   logic [32:0]            rsub;
   logic                   ge;
   logic [31:0]            wr;
   logic signed [63:0]     p64;
   logic [SINE_TABLE_BITS-1:0] sidx;
   logic [1:0]             quad;
   logic [QBITS-1:0]       rr;
   logic [LIW-1:0]         li;
   logic [16:0]            smag;
   logic signed [34:0]     osum;
   logic [32:0]            qc;
   logic signed [34:0]     sq;
   logic signed [34:0]     qsum;

   function automatic logic signed [31:0] sat_q16(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   for (genvar g = 0; g <= QSIZE; g++) begin : g_lut
      assign sine_lut[g] = quarter_sine(g, QBITS);
   end

   assign widx   = AW'(req_key_index);
   assign key_ok = 32'(req_key_index) < 32'(MAX_KEYS);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && key_ok) begin
         times_mem[widx]  <= req_key_time;
         values_mem[widx] <= req_key_value;
      end
      if (cmd.rd_en) begin
         rd_time_ff <= times_mem[rd_addr];
         rd_val_ff  <= values_mem[rd_addr];
      end
   end

   always_comb begin
      span33 = {rd_time_ff[31], rd_time_ff} - {ta_ff[31], ta_ff};
      mdiff  = {time_ff[31], time_ff} - {ta_ff[31], ta_ff};
      mmag   = mdiff[32] ? 33'(-mdiff) : 33'(mdiff);
      adiff  = {t_ff[32], t_ff} - {{2{ta_ff[31]}}, ta_ff};
      amag   = adiff[33] ? 34'(-adiff) : 34'(adiff);
      dv33   = {rd_val_ff[31], rd_val_ff} - {va_ff[31], va_ff};
      vmag   = dv33[32] ? 33'(-dv33) : 33'(dv33);
      rs     = {rem_ff, dq_ff[63]};
      rsub   = rs - {1'b0, den_ff};
      ge     = rs >= {1'b0, den_ff};
      wr     = (neg_ff && rem_ff != 32'd0) ? den_ff - rem_ff : rem_ff;
      p64    = time_ff * osc_frequency;
      sidx   = ang_ff[31 -: SINE_TABLE_BITS];
      quad   = sidx[SINE_TABLE_BITS-1 -: 2];
      rr     = sidx[QBITS-1:0];
      li     = quad[0] ? LIW'(QSIZE) - {1'b0, rr} : {1'b0, rr};
      smag   = sine_lut[li];
      osum   = {{3{base_ff[31]}}, base_ff} + {oprod_ff[49], oprod_ff[49:16]};
      qc     = (dq_ff > 64'h1_0000_0000) ? 33'h1_0000_0000 : dq_ff[32:0];
      sq     = neg_ff ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
      qsum   = {{3{va_ff[31]}}, va_ff} + sq;

      status.wrap   = loop_enable && (span33 > 33'sd0);
      status.hit    = t_ff <= $signed({rd_time_ff[31], rd_time_ff});
      status.dt_pos = span33 > 33'sd0;
      status.ovf    = |prod_ff[65:64];
   end

   always_comb begin
      time_in  = time_ff;
      base_in  = base_ff;
      res_in   = res_ff;
      ta_in    = ta_ff;
      va_in    = va_ff;
      out_in   = out_ff;
      t_in     = t_ff;
      ang_in   = ang_ff;
      sin_in   = sin_ff;
      oprod_in = oprod_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      den_in   = den_ff;
      pplo_in  = pplo_ff;
      pphi_in  = pphi_ff;
      prod_in  = prod_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            time_in = req_sample_time;
            base_in = req_base_value;
            res_in  = req_base_value;
         end
         OP_OSC_MUL: ang_in = p64[31:0] + {osc_phase_turns, 16'h0000};
         OP_OSC_SIN: sin_in = quad[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
         OP_OSC_AMP: oprod_in = osc_amplitude * sin_ff;
         OP_OSC_FIN: res_in = sat_q16(osum);
         OP_KEY0: begin
            ta_in = rd_time_ff;
            va_in = rd_val_ff;
         end
         OP_RES_RD: res_in = rd_val_ff;
         OP_LOAD_MOD: begin
            dq_in  = 64'(mmag);
            rem_in = 32'd0;
            den_in = span33[31:0];
            neg_in = mdiff[32];
         end
         OP_T_PLAIN: t_in = {time_ff[31], time_ff};
         OP_DIV_STEP: begin
            rem_in = ge ? rsub[31:0] : rs[31:0];
            dq_in  = {dq_ff[62:0], ge};
         end
         OP_WRAP: t_in = {ta_ff[31], ta_ff} + {1'b0, wr};
         OP_ADVANCE: begin
            ta_in = rd_time_ff;
            va_in = rd_val_ff;
         end
         OP_SEG: begin
            ua_in  = amag;
            ub_in  = vmag;
            neg_in = adiff[33] != dv33[32];
            den_in = span33[31:0];
         end
         OP_MUL_LO: pplo_in = ua_ff[16:0] * ub_ff;
         OP_MUL_HI: pphi_in = ua_ff[33:17] * ub_ff;
         OP_MUL_SUM: prod_in = 66'(pplo_ff) + (66'(pphi_ff) << 17);
         OP_LOAD_DIV: begin
            dq_in  = prod_ff[63:0];
            rem_in = 32'd0;
         end
         OP_RES_VA: res_in = va_ff;
         OP_RES_SAT: res_in = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         OP_RES_QUOT: res_in = sat_q16(qsum);
         OP_EMIT: out_in = res_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff  <= time_in;
      base_ff  <= base_in;
      res_ff   <= res_in;
      ta_ff    <= ta_in;
      va_ff    <= va_in;
      out_ff   <= out_in;
      t_ff     <= t_in;
      ang_ff   <= ang_in;
      sin_ff   <= sin_in;
      oprod_ff <= oprod_in;
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      pplo_ff  <= pplo_in;
      pphi_ff  <= pphi_in;
      prod_ff  <= prod_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
   end

   assign rsp_anim_value = out_ff;

endmodule

// ----- design/ksa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ksa_ctrl
// Sequencer: handshakes, mode dispatch, key search, divider step count.
// ----------------------------------------------------------------------------
module ksa_ctrl #(
   parameter int MAX_KEYS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_action,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    motion_mode,
   input  logic [4:0]                    key_count,
   output ksa_pkg::cmd_type              cmd,
   output logic [$clog2(MAX_KEYS)-1:0]   rd_addr,
   input  ksa_pkg::status_type           status
);
   import ksa_pkg::*;

   localparam int AW = $clog2(MAX_KEYS);
   localparam int KW = $clog2(MAX_KEYS + 1);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_OSC_MUL = 5'd1;
   localparam logic [4:0] ST_OSC_SIN = 5'd2;
   localparam logic [4:0] ST_OSC_AMP = 5'd3;
   localparam logic [4:0] ST_OSC_FIN = 5'd4;
   localparam logic [4:0] ST_KEY0    = 5'd5;
   localparam logic [4:0] ST_SPAN    = 5'd6;
   localparam logic [4:0] ST_MOD     = 5'd7;
   localparam logic [4:0] ST_WRAP    = 5'd8;
   localparam logic [4:0] ST_SRD     = 5'd9;
   localparam logic [4:0] ST_SCMP    = 5'd10;
   localparam logic [4:0] ST_SEG     = 5'd11;
   localparam logic [4:0] ST_MUL_LO  = 5'd12;
   localparam logic [4:0] ST_MUL_HI  = 5'd13;
   localparam logic [4:0] ST_MUL_SUM = 5'd14;
   localparam logic [4:0] ST_OVF     = 5'd15;
   localparam logic [4:0] ST_DIV     = 5'd16;
   localparam logic [4:0] ST_QUOT    = 5'd17;
   localparam logic [4:0] ST_EMIT    = 5'd18;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]    n;
   logic             cnt_last;

   assign n        = (32'(key_count) > MAX_KEYS) ? KW'(MAX_KEYS) : KW'(key_count);
   assign cnt_last = cnt_ff == CNT_W'(DIV_STEPS - 1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_IDLE;
      cmd.rd_en    = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op = OP_CAPTURE;
                  case (motion_mode)
                     MODE_OSC: state_in = ST_OSC_MUL;
                     MODE_KEYS: begin
                        if (n == KW'(0)) begin
                           state_in = ST_EMIT;
                        end else begin
                           cmd.rd_en = 1'b1;
                           state_in  = ST_KEY0;
                        end
                     end
                     default: state_in = ST_EMIT;
                  endcase
               end
            end
         end
         ST_OSC_MUL: begin
            cmd.op   = OP_OSC_MUL;
            state_in = ST_OSC_SIN;
         end
         ST_OSC_SIN: begin
            cmd.op   = OP_OSC_SIN;
            state_in = ST_OSC_AMP;
         end
         ST_OSC_AMP: begin
            cmd.op   = OP_OSC_AMP;
            state_in = ST_OSC_FIN;
         end
         ST_OSC_FIN: begin
            cmd.op   = OP_OSC_FIN;
            state_in = ST_EMIT;
         end
         ST_KEY0: begin
            if (n == KW'(1)) begin
               cmd.op   = OP_RES_RD;
               state_in = ST_EMIT;
            end else begin
               cmd.op    = OP_KEY0;
               cmd.rd_en = 1'b1;
               rd_addr   = AW'(32'(n) - 1);
               state_in  = ST_SPAN;
            end
         end
         ST_SPAN: begin
            idx_in = '0;
            cnt_in = '0;
            if (status.wrap) begin
               cmd.op   = OP_LOAD_MOD;
               state_in = ST_MOD;
            end else begin
               cmd.op   = OP_T_PLAIN;
               state_in = ST_SRD;
            end
         end
         ST_MOD: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            cmd.op   = OP_WRAP;
            state_in = ST_SRD;
         end
         ST_SRD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = idx_ff + AW'(1);
            state_in  = ST_SCMP;
         end
         ST_SCMP: begin
            if (status.hit) begin
               state_in = ST_SEG;
            end else if (32'(idx_ff) + 32'd2 >= 32'(n)) begin
               cmd.op   = OP_RES_RD;
               state_in = ST_EMIT;
            end else begin
               cmd.op   = OP_ADVANCE;
               idx_in   = idx_ff + AW'(1);
               state_in = ST_SRD;
            end
         end
         ST_SEG: begin
            if (status.dt_pos) begin
               cmd.op   = OP_SEG;
               state_in = ST_MUL_LO;
            end else begin
               cmd.op   = OP_RES_VA;
               state_in = ST_EMIT;
            end
         end
         ST_MUL_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_MUL_SUM;
         end
         ST_MUL_SUM: begin
            cmd.op   = OP_MUL_SUM;
            state_in = ST_OVF;
         end
         ST_OVF: begin
            cnt_in = '0;
            if (status.ovf) begin
               cmd.op   = OP_RES_SAT;
               state_in = ST_EMIT;
            end else begin
               cmd.op   = OP_LOAD_DIV;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            cmd.op   = OP_RES_QUOT;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result word not loaded on emit");

   a_rise_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result valid rose outside emit");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> (32'(idx_ff) + 32'd2 <= 32'(n)))
      else $error("key search ran past key count");

endmodule

// ----- design/keyframe_and_sine_param_animator_core.sv -----
// ----------------------------------------------------------------------------
// keyframe_and_sine_param_animator_core
// Parameter animator: static, table-sine oscillation, or keyframe interpolation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | action, key slot/time/value, time, base
//  rsp     | out       | rsp_valid/rsp_stall  | anim_value (Q16.16, saturated)
//  csr     | in/out    | APB, pready tied 1   | six registers at 4*index
//
//  Oscillate steps: product, sine table, amplitude product, sum.
//  Keyframes compare one key at a time; with looping they add a modulo on the
//  shared 1-bit-per-cycle divider, and an interpolated segment adds a split
//  multiply and a 64-step divide.
//  Reset clears control and registers only; the key table holds junk until loaded.
//  req_stall stays high while a word is in work; the result waits in an output
//  register while rsp_stall is high.
module keyframe_and_sine_param_animator_core #(
   parameter int MAX_KEYS        = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [3:0]                  req_key_index,
   input  logic signed [31:0]          req_key_time,
   input  logic signed [31:0]          req_key_value,
   input  logic signed [31:0]          req_sample_time,
   input  logic signed [31:0]          req_base_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_anim_value,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ksa_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import ksa_pkg::*;

   logic [1:0]         mode_ff, mode_in;
   logic signed [31:0] amp_ff, amp_in;
   logic signed [31:0] freq_ff, freq_in;
   logic [15:0]        phase_ff, phase_in;
   logic               loop_ff, loop_in;
   logic [4:0]         count_ff, count_in;
   logic               wr_en;
   logic [2:0]         reg_idx;

   cmd_type                     cmd;
   status_type                  status;
   logic [$clog2(MAX_KEYS)-1:0] rd_addr;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      mode_in  = mode_ff;
      amp_in   = amp_ff;
      freq_in  = freq_ff;
      phase_in = phase_ff;
      loop_in  = loop_ff;
      count_in = count_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODE:  mode_in  = csr_pwdata[1:0];
            REG_AMP:   amp_in   = csr_pwdata;
            REG_FREQ:  freq_in  = csr_pwdata;
            REG_PHASE: phase_in = csr_pwdata[15:0];
            REG_LOOP:  loop_in  = csr_pwdata[0];
            REG_COUNT: count_in = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:  csr_prdata = {30'd0, mode_ff};
         REG_AMP:   csr_prdata = amp_ff;
         REG_FREQ:  csr_prdata = freq_ff;
         REG_PHASE: csr_prdata = {16'd0, phase_ff};
         REG_LOOP:  csr_prdata = {31'd0, loop_ff};
         REG_COUNT: csr_prdata = {27'd0, count_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STATIC;
         amp_ff   <= 32'sd0;
         freq_ff  <= 32'sd65536;
         phase_ff <= 16'd0;
         loop_ff  <= 1'b1;
         count_ff <= 5'd0;
      end else begin
         mode_ff  <= mode_in;
         amp_ff   <= amp_in;
         freq_ff  <= freq_in;
         phase_ff <= phase_in;
         loop_ff  <= loop_in;
         count_ff <= count_in;
      end
   end

   ksa_ctrl #(
      .MAX_KEYS(MAX_KEYS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .motion_mode (mode_ff),
      .key_count   (count_ff),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .status      (status)
   );

   ksa_dpath #(
      .MAX_KEYS        (MAX_KEYS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .status          (status),
      .req_key_index   (req_key_index),
      .req_key_time    (req_key_time),
      .req_key_value   (req_key_value),
      .req_sample_time (req_sample_time),
      .req_base_value  (req_base_value),
      .osc_amplitude   (amp_ff),
      .osc_frequency   (freq_ff),
      .osc_phase_turns (phase_ff),
      .loop_enable     (loop_ff),
      .rsp_anim_value  (rsp_anim_value)
   );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animator testbench
// Loads keyframe tables and evaluates the animated value in the static,
// oscillate and keyframe modes across several register settings. A local
// predictor of the value, kept in a small scoreboard, checks each output word.
// ----------------------------------------------------------------------------
module testbench;
   import ksa_pkg::*;

   localparam int NKEYS = 16;
   localparam int SBITS = 10;
   localparam longint LIMIT = 3000000;

   class anim_scoreboard;
      logic [1:0]  mode;
      logic signed [31:0] amp, freq;
      logic [15:0] phase;
      logic        loop_on;
      logic [4:0]  count;
      logic signed [31:0] ktime [NKEYS];
      logic signed [31:0] kval [NKEYS];
      logic signed [31:0] pending [$];
      int errors;
      int checked;

      function new();
         mode = MODE_STATIC; amp = 0; freq = 65536; phase = 0;
         loop_on = 1; count = 0; errors = 0; checked = 0;
         foreach (ktime[i]) begin
            ktime[i] = 0;
            kval[i] = 0;
         end
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint sine_at(int unsigned idx);
         int unsigned q, quad, r;
         logic [63:0] x, x2, t, s, q16;
         q = 1 << (SBITS - 2);
         quad = (idx >> (SBITS - 2)) & 3;
         r = idx & (q - 1);
         if (quad & 1) r = q - r;
         x   = (64'(r) * 64'd1686629713) >> (SBITS - 2);
         x2  = (x * x) >> 30;
         t   = 64'd1073741824 - ((x2 * 64'd1073741824) >> 30) / 64'd110;
         t   = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
         t   = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
         t   = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
         t   = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
         s   = (x * t) >> 30;
         q16 = (s + 64'd8192) >> 14;
         if (q16 > 64'd65536) q16 = 64'd65536;
         return (quad & 2) ? -longint'(q16) : longint'(q16);
      endfunction

      function longint osc_value(longint t, longint base);
         longint p, prod;
         logic [31:0] ang;
         p = t * longint'(freq);
         ang = p[31:0] + {phase, 16'h0};
         prod = longint'(amp) * sine_at(ang >> (32 - SBITS));
         return clamp32(base + (prod >>> 16));
      endfunction

      function longint lerp(longint t, longint ta, longint va, longint dt, longint dv);
         longint a;
         bit neg;
         logic [127:0] ua, ub, q;
         a = t - ta;
         neg = (a < 0) != (dv < 0);
         ua = 128'((a < 0) ? -a : a);
         ub = 128'((dv < 0) ? -dv : dv);
         q = (ua * ub) / 128'(dt);
         if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
         return clamp32(neg ? va - longint'(q[63:0]) : va + longint'(q[63:0]));
      endfunction

      function longint key_value_at(longint t, longint base);
         int n;
         longint t0, span, rem, ta, tb;
         n = (count > NKEYS) ? NKEYS : int'(count);
         if (n == 0) return base;
         if (n == 1) return longint'(kval[0]);
         if (loop_on) begin
            t0 = longint'(ktime[0]);
            span = longint'(ktime[n-1]) - t0;
            if (span > 0) begin
               rem = (t - t0) % span;
               if (rem < 0) rem += span;
               t = t0 + rem;
            end
         end
         for (int i = 0; i + 1 < n; i++) begin
            ta = longint'(ktime[i]);
            tb = longint'(ktime[i+1]);
            if (t <= tb) begin
               if (tb - ta <= 0) return longint'(kval[i]);
               return lerp(t, ta, longint'(kval[i]), tb - ta,
                           longint'(kval[i+1]) - longint'(kval[i]));
            end
         end
         return longint'(kval[n-1]);
      endfunction

      function void note_word(logic act, logic [3:0] idx, logic signed [31:0] kt,
                              logic signed [31:0] kv, logic signed [31:0] st,
                              logic signed [31:0] bv);
         longint r;
         if (act == ACT_LOAD) begin
            ktime[idx] = kt;
            kval[idx] = kv;
            return;
         end
         if (mode == MODE_OSC) r = osc_value(longint'(st), longint'(bv));
         else if (mode == MODE_KEYS) r = key_value_at(longint'(st), longint'(bv));
         else r = longint'(bv);
         pending.insert(pending.size(), r[31:0]);
      endfunction

      function void check_word(logic signed [31:0] got);
         logic signed [31:0] want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected output word %0d", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("anim_value mismatch: expected %0d got %0d", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_action = 0;
   logic [3:0] req_key_index = 0;
   logic signed [31:0] req_key_time = 0, req_key_value = 0;
   logic signed [31:0] req_sample_time = 0, req_base_value = 0;
   logic req_stall, rsp_valid, csr_pready;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_anim_value;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;

   anim_scoreboard board;
   longint cycles = 0;
   bit stall_on = 0;

   keyframe_and_sine_param_animator_core u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_anim_value);
      if (stall_on) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 0;
   end

   task automatic reg_write(logic [2:0] idx, logic [31:0] val);
      req_valid <= 0;
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_AW'(idx) << 2; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_MODE:  board.mode = val[1:0];
         REG_AMP:   board.amp = val;
         REG_FREQ:  board.freq = val;
         REG_PHASE: board.phase = val[15:0];
         REG_LOOP:  board.loop_on = val[0];
         REG_COUNT: board.count = val[4:0];
         default: ;
      endcase
   endtask

   task automatic send_word(logic act, logic [3:0] idx, logic [31:0] kt, logic [31:0] kv,
                            logic [31:0] st, logic [31:0] bv);
      req_valid <= 1; req_action <= act; req_key_index <= idx;
      req_key_time <= kt; req_key_value <= kv;
      req_sample_time <= st; req_base_value <= bv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(act, idx, kt, kv, st, bv);
      if ($urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic load_table(int n, bit sorted);
      logic [31:0] t;
      t = $urandom_range(0, 1) ? -$urandom_range(0, 300000) : $urandom_range(0, 300000);
      for (int i = 0; i < n; i++) begin
         if (sorted) t = t + ($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 200000));
         else t = $urandom;
         send_word(ACT_LOAD, 4'(i), t, $urandom_range(0, 3) == 0 ? $urandom :
                   $urandom_range(0, 2000000) - 1000000, $urandom, $urandom);
      end
   endtask

   function automatic logic [31:0] any32();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic eval_burst(int n);
      logic [31:0] t;
      for (int i = 0; i < n; i++) begin
         t = ($urandom_range(0, 3) == 0) ? any32() : $urandom_range(0, 4000000) - 2000000;
         if ($urandom_range(0, 9) == 0)
            send_word(ACT_LOAD, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
         else
            send_word(ACT_EVAL, 4'($urandom), $urandom, $urandom, t, any32());
      end
   endtask

   initial begin
      int n;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_word(ACT_EVAL, 0, 0, 0, 32'h7fffffff, 32'h80000000);
      send_word(ACT_EVAL, 0, 0, 0, 32'h80000000, 32'h7fffffff);
      send_word(ACT_LOAD, 4'hf, 32'h7fffffff, 32'h80000000, 0, 0);
      drain();
      reg_write(REG_MODE, MODE_KEYS);
      send_word(ACT_EVAL, 0, 0, 0, 100, 32'h12345);
      load_table(4, 1);
      reg_write(REG_COUNT, 1);
      send_word(ACT_EVAL, 0, 0, 0, 5, 7);
      drain();
      reg_write(REG_COUNT, 4);
      for (int i = 0; i < 5; i++)
         send_word(ACT_EVAL, 0, 0, 0, board.ktime[0] - 65536 + i * 100000, 0);
      drain();
      reg_write(REG_LOOP, 0);
      send_word(ACT_EVAL, 0, 0, 0, 32'h7fffffff, 0);
      send_word(ACT_EVAL, 0, 0, 0, 32'h80000000, 0);
      drain();
      reg_write(REG_MODE, MODE_OSC);
      reg_write(REG_AMP, 32'h7fffffff);
      reg_write(REG_PHASE, 16'hffff);
      send_word(ACT_EVAL, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);
      send_word(ACT_EVAL, 0, 0, 0, 32'h4000, 32'h80000000);
      drain();
      reg_write(REG_MODE, 2'd3);
      send_word(ACT_EVAL, 0, 0, 0, 1, 32'h55aa);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         stall_on = (ph % 3 != 0);
         reg_write(REG_MODE, ph % 4 == 0 ? MODE_OSC : (ph % 5 == 0 ? MODE_STATIC : MODE_KEYS));
         reg_write(REG_AMP, ph % 2 ? 32'h80000000 : $urandom_range(0, 1) ? any32() :
                   $urandom_range(0, 400000) - 200000);
         reg_write(REG_FREQ, ph == 1 ? 32'h7fffffff : ph == 5 ? 32'h80000000 : any32());
         reg_write(REG_PHASE, $urandom);
         reg_write(REG_LOOP, $urandom_range(0, 1));
         n = (ph == 3) ? 16 : $urandom_range(0, 16);
         load_table(n, ph != 7);
         if (ph == 9) begin
            load_table(16, 1);
            n = 31;
         end
         reg_write(REG_COUNT, n);
         eval_burst(40);
         drain();
      end

      $display("Covered %0d output words over static, oscillate and keyframe modes,",
               board.checked);
      $display("with looping on and off and tables of 0 to 16 keys.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
